### sv/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/rau_pkg.sv
package rau_pkg;
   localparam int WIDTH = 32;
   localparam int DW = 64;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_DIV_ZERO = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;
endpackage

### sv/rational_arith_unit.sv
// The response strobe follows S_PREP when the result is settled there (a divide skips S_MUL3);
// otherwise the unit runs Euclid remainder steps in S_GCD, each a divider launch and a full
// divider pass, then divides both parts by the gcd in S_QN and S_QD; the strobe follows S_DONE.
// Throughput: one request at a time; busy stays high through the strobe cycle, so the next
// request is taken in the cycle after the strobe at the earliest. The receiver cannot stall it.
// Reset is synchronous and active high; it returns the sequencer to idle and clears the strobe.
`include "assert_macros.svh"
module rational_arith_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_command,
   input  logic signed [31:0]                req_a_num,
   input  logic [30:0]                       req_a_den,
   input  logic signed [31:0]                req_b_num,
   input  logic [30:0]                       req_b_den,
   output logic                              rsp_valid,
   output logic signed [31:0]                rsp_res_num,
   output logic [30:0]                       rsp_res_den,
   output logic [1:0]                        rsp_status
);
   import rau_pkg::*;

   // Sequencer. One shared 32x32 multiplier forms the products in turn, one shared
   // restoring divider (one quotient bit a cycle) performs every remainder and quotient.
   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_MUL1 = 9'b000000010,
      S_MUL2 = 9'b000000100,
      S_MUL3 = 9'b000001000,
      S_PREP = 9'b000010000,
      S_GCD  = 9'b000100000,
      S_QN   = 9'b001000000,
      S_QD   = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]               cmd_ff;
   logic signed [31:0]       an_ff, bn_ff;
   logic [30:0]              ad_ff, bd_ff;
   logic signed [DW-1:0]     p1_ff, p2_ff, p1_in, p2_in;
   logic [DW-1:0]            den_ff, den_in;   // magnitude of denominator product
   logic                     dneg_ff, dneg_in;
   logic [DW-1:0]            nm_ff, dm_ff, gx_ff, gy_ff;
   logic                     neg_ff;
   // Divider.
   logic [DW-1:0]            dv_q_ff, dv_r_ff, dv_d_ff;
   logic [6:0]               dv_cnt_ff;
   logic                     dv_run_ff;
   logic                     dv_go;
   logic [DW-1:0]            dv_n_go, dv_d_go;
   logic [DW:0]              dv_try;
   logic [DW-1:0]            dv_rsh;
   // Result.
   logic                     vld_ff;
   logic signed [31:0]       rnum_ff;
   logic [30:0]              rden_ff;
   logic [1:0]               rst_ff;

   // Shared multiplier operands.
   logic signed [32:0]       mx, my;
   logic signed [65:0]       mp;

   logic [DW-1:0]            lim;
   assign lim = DW'(1) << (WIDTH - 1);

   logic early;      // result already settled before reduction
   logic [1:0] early_st;
   always_comb begin
      early = 1'b0; early_st = ST_OK;
      if (ad_ff == '0 || bd_ff == '0) begin early = 1'b1; early_st = ST_ZERO_DEN; end
      else if (cmd_ff == CMD_MUL && (an_ff == 0 || bn_ff == 0)) early = 1'b1;
      else if (cmd_ff == CMD_DIV && bn_ff == 0) begin early = 1'b1; early_st = ST_DIV_ZERO; end
      else if (cmd_ff == CMD_DIV && an_ff == 0) early = 1'b1;
      else if (p1_ff == 0) early = 1'b1;
   end

   always_comb begin
      mx = '0; my = '0;
      unique case (state_ff)
         S_MUL1: begin
            mx = 33'(an_ff);
            my = (cmd_ff == CMD_MUL) ? 33'(bn_ff) : $signed({2'b00, bd_ff});
         end
         S_MUL2: begin
            mx = (cmd_ff == CMD_DIV) ? $signed({2'b00, ad_ff}) : 33'(bn_ff);
            my = (cmd_ff == CMD_DIV) ? 33'(bn_ff) : $signed({2'b00, ad_ff});
         end
         S_MUL3: begin
            mx = $signed({2'b00, ad_ff});
            my = $signed({2'b00, bd_ff});
         end
         default: ;
      endcase
      mp = mx * my;
   end

   // Restoring divider step.
   always_comb begin
      dv_rsh = {dv_r_ff[DW-2:0], dv_q_ff[DW-1]};
      dv_try = {1'b0, dv_rsh} - {1'b0, dv_d_ff};
   end

   always_comb begin
      state_in = state_ff;
      p1_in = p1_ff; p2_in = p2_ff; den_in = den_ff; dneg_in = dneg_ff;
      dv_go = 1'b0; dv_n_go = gx_ff; dv_d_go = gy_ff;
      unique case (state_ff)
         S_IDLE: if (start && !vld_ff) state_in = S_MUL1;
         S_MUL1: begin p1_in = DW'(mp); state_in = S_MUL2; end
         S_MUL2: begin
            if (cmd_ff == CMD_DIV) begin
               den_in = (mp < 0) ? DW'(-mp) : DW'(mp);
               dneg_in = mp < 0;
               state_in = S_PREP;
            end else begin
               p2_in = DW'(mp); state_in = S_MUL3;
            end
         end
         S_MUL3: begin
            den_in = DW'(mp); dneg_in = 1'b0;
            if (cmd_ff == CMD_ADD) p1_in = p1_ff + p2_ff;
            else if (cmd_ff == CMD_SUB) p1_in = p1_ff - p2_ff;
            state_in = S_PREP;
         end
         S_PREP: state_in = early ? S_IDLE : S_GCD;
         S_GCD: begin
            if (!dv_run_ff) begin
               if (gy_ff == '0) begin
                  dv_go = 1'b1; dv_n_go = nm_ff; dv_d_go = gx_ff;
                  state_in = S_QN;
               end else begin
                  dv_go = 1'b1;
               end
            end
         end
         S_QN: if (!dv_run_ff) begin
            dv_go = 1'b1; dv_n_go = dm_ff; dv_d_go = gx_ff; state_in = S_QD;
         end
         S_QD: if (!dv_run_ff) state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   logic ovf;
   assign ovf = (dv_q_ff > lim - 1'b1)
             || (neg_ff ? (nm_ff > lim) : (nm_ff > lim - 1'b1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dv_run_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= (state_ff == S_PREP && early) || (state_ff == S_DONE);
         if (dv_go) dv_run_ff <= 1'b1;
         else if (dv_run_ff && dv_cnt_ff == 7'(DW - 1)) dv_run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff <= p1_in; p2_ff <= p2_in; den_ff <= den_in; dneg_ff <= dneg_in;
      if (state_ff == S_IDLE && start && !vld_ff) begin
         cmd_ff <= req_command;
         an_ff <= req_a_num; ad_ff <= req_a_den;
         bn_ff <= req_b_num; bd_ff <= req_b_den;
      end
      if (dv_go) begin
         dv_q_ff <= dv_n_go; dv_r_ff <= '0; dv_d_ff <= dv_d_go; dv_cnt_ff <= '0;
      end else if (dv_run_ff) begin
         dv_cnt_ff <= dv_cnt_ff + 7'd1;
         if (!dv_try[DW]) begin
            dv_r_ff <= dv_try[DW-1:0]; dv_q_ff <= {dv_q_ff[DW-2:0], 1'b1};
         end else begin
            dv_r_ff <= dv_rsh; dv_q_ff <= {dv_q_ff[DW-2:0], 1'b0};
         end
      end
      if (state_ff == S_PREP) begin
         neg_ff <= (p1_ff < 0) != dneg_ff;
         nm_ff <= (p1_ff < 0) ? DW'(-p1_ff) : DW'(p1_ff);
         dm_ff <= den_ff;
         gx_ff <= (p1_ff < 0) ? DW'(-p1_ff) : DW'(p1_ff);
         gy_ff <= den_ff;
         rnum_ff <= '0; rden_ff <= 31'd1; rst_ff <= early_st;
      end
      // A finished remainder step: x <= y, y <= remainder.
      if (state_ff == S_GCD && dv_run_ff && dv_cnt_ff == 7'(DW - 1)) begin
         gx_ff <= gy_ff;
         gy_ff <= dv_try[DW] ? dv_rsh : dv_try[DW-1:0];
      end
      if (state_ff == S_QN && !dv_run_ff)
         nm_ff <= dv_q_ff;   // reduced numerator held while denominator divides
      if (state_ff == S_DONE) begin
         if (ovf) begin
            rnum_ff <= '0; rden_ff <= 31'd1; rst_ff <= ST_OVERFLOW;
         end else begin
            rnum_ff <= neg_ff ? -32'(nm_ff) : 32'(nm_ff);
            rden_ff <= 31'(dv_q_ff);
            rst_ff <= ST_OK;
         end
      end
   end

   assign busy = (state_ff != S_IDLE) || vld_ff;
   assign rsp_valid = vld_ff;
   assign rsp_res_num = rnum_ff;
   assign rsp_res_den = rden_ff;
   assign rsp_status = rst_ff;

   `ASSERT_IMPL(a_busy_rsp, clock, reset, rsp_valid, busy)
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_IMPL(a_status_zero, clock, reset, rsp_valid && rsp_status != ST_OK,
                rsp_res_num == 0 && rsp_res_den == 31'd1)
endmodule
